// ===== hw/rtl/pts_pkg.sv =====
// periodic task scheduler: shared constants, command codes and the
// control and status bundles between controller and datapath
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package pts_pkg;

  // default parameter values
  localparam int MAX_TASKS_DEF = 16;
  localparam int TIME_BITS_DEF = 48;

  // fixed port widths
  localparam int CMD_W    = 2;
  localparam int INDEX_W  = 4;
  localparam int ID_W     = 32;
  localparam int PERIOD_W = 32;
  localparam int COUNT_W  = 5;
  localparam int NOW_W    = 48;

  // command codes
  localparam logic [CMD_W-1:0] CMD_LOAD   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_COMMIT = 2'd1;
  localparam logic [CMD_W-1:0] CMD_TICK   = 2'd2;

  // controller to datapath
  typedef struct packed {
    logic load_wr;     // write one table row
    logic commit;      // set row count, mark table changed
    logic tick_start;  // capture time, clear fired marks
    logic rd_en;       // read the row at the walk index
    logic arm_wr;      // re-arm the row read last cycle
    logic fire_start;  // clear earliest before the fire walk
    logic fire_wr;     // fire and re-arm the row if due
    logic emit_fire;   // present one firing result
    logic emit_sum;    // present the summary result
  } pts_ctl_t;

  // datapath to controller
  typedef struct packed {
    logic changed;     // table changed since last tick
    logic en_cur;      // row at walk index is active
    logic fired_cur;   // row at walk index fired this tick
    logic reached;     // now has reached the earliest due time
  } pts_sts_t;

endpackage

`default_nettype wire

// ===== hw/rtl/pts_ctrl.sv =====
// periodic task scheduler: sequencing state machine and row walk counter
// depends on pts_pkg
`timescale 1ns / 1ps
`default_nettype none

module pts_ctrl #(
  parameter int MAX_TASKS = pts_pkg::MAX_TASKS_DEF,
  localparam int CNT_W = $clog2(MAX_TASKS + 1),
  localparam int IDX_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     start,
  input  wire logic [pts_pkg::CMD_W-1:0] in_command,
  input  wire logic [CNT_W-1:0]         rows,
  input  wire pts_pkg::pts_sts_t        sts,
  output pts_pkg::pts_ctl_t             ctl,
  output logic [IDX_W-1:0]              idx,
  output logic                          busy
);
  import pts_pkg::*;

  typedef enum logic [9:0] {
    S_IDLE = 10'b00_0000_0001,
    S_ARD  = 10'b00_0000_0010,
    S_AWR  = 10'b00_0000_0100,
    S_CHK  = 10'b00_0000_1000,
    S_BRD  = 10'b00_0001_0000,
    S_BWR  = 10'b00_0010_0000,
    S_CSC  = 10'b00_0100_0000,
    S_COUT = 10'b00_1000_0000,
    S_SUM  = 10'b01_0000_0000,
    S_SPARE = 10'b10_0000_0000
  } state_t;

  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              done;

  assign done = (cnt_r == rows);
  assign idx  = cnt_r[IDX_W-1:0];
  assign busy = (state_r != S_IDLE);

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    ctl       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          unique case (in_command)
            CMD_LOAD:   ctl.load_wr = 1'b1;
            CMD_COMMIT: ctl.commit = 1'b1;
            CMD_TICK: begin
              ctl.tick_start = 1'b1;
              cnt_nxt        = '0;
              state_nxt      = sts.changed ? S_ARD : S_CHK;
            end
            default: ;
          endcase
        end
      end
      // re-arm walk after a table change
      S_ARD: begin
        if (done) begin
          state_nxt = S_CHK;
        end else if (sts.en_cur) begin
          ctl.rd_en = 1'b1;
          state_nxt = S_AWR;
        end else begin
          cnt_nxt = cnt_r + CNT_W'(1);
        end
      end
      S_AWR: begin
        ctl.arm_wr = 1'b1;
        cnt_nxt    = cnt_r + CNT_W'(1);
        state_nxt  = S_ARD;
      end
      // decide whether anything can be due
      S_CHK: begin
        cnt_nxt = '0;
        if (sts.reached) begin
          ctl.fire_start = 1'b1;
          state_nxt      = S_BRD;
        end else begin
          state_nxt = S_SUM;
        end
      end
      // fire walk
      S_BRD: begin
        if (done) begin
          cnt_nxt   = '0;
          state_nxt = S_CSC;
        end else if (sts.en_cur) begin
          ctl.rd_en = 1'b1;
          state_nxt = S_BWR;
        end else begin
          cnt_nxt = cnt_r + CNT_W'(1);
        end
      end
      S_BWR: begin
        ctl.fire_wr = 1'b1;
        cnt_nxt     = cnt_r + CNT_W'(1);
        state_nxt   = S_BRD;
      end
      // report walk over fired rows
      S_CSC: begin
        if (done) begin
          state_nxt = S_SUM;
        end else if (sts.fired_cur) begin
          ctl.rd_en = 1'b1;
          state_nxt = S_COUT;
        end else begin
          cnt_nxt = cnt_r + CNT_W'(1);
        end
      end
      S_COUT: begin
        ctl.emit_fire = 1'b1;
        cnt_nxt       = cnt_r + CNT_W'(1);
        state_nxt     = S_CSC;
      end
      S_SUM: begin
        ctl.emit_sum = 1'b1;
        state_nxt    = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

`ifndef SYNTH
  // walk counter never passes the row count
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> (cnt_r <= rows))
    else $error("walk counter beyond row count");

  // a firing result always follows an id read
  a_cout_after_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_COUT) |-> ($past(state_r) == S_CSC))
    else $error("report state without preceding scan");

  // summary returns to idle
  a_sum_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SUM) |=> (state_r == S_IDLE))
    else $error("summary did not end the tick");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/pts_dp.sv =====
// periodic task scheduler: task table memories, due-time arithmetic,
// earliest-due tracking and result registers
// depends on pts_pkg
`timescale 1ns / 1ps
`default_nettype none

module pts_dp #(
  parameter int MAX_TASKS = pts_pkg::MAX_TASKS_DEF,
  parameter int TIME_BITS = pts_pkg::TIME_BITS_DEF,
  localparam int CNT_W = $clog2(MAX_TASKS + 1),
  localparam int IDX_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire pts_pkg::pts_ctl_t             ctl,
  input  wire logic [IDX_W-1:0]              idx,
  input  wire logic [pts_pkg::INDEX_W-1:0]   in_row_index,
  input  wire logic [pts_pkg::ID_W-1:0]      in_row_id,
  input  wire logic                          in_row_active,
  input  wire logic [pts_pkg::PERIOD_W-1:0]  in_row_interval,
  input  wire logic [pts_pkg::COUNT_W-1:0]   in_row_count,
  input  wire logic [pts_pkg::NOW_W-1:0]     in_now_ms,
  output pts_pkg::pts_sts_t                  sts,
  output logic [CNT_W-1:0]                   rows,
  output logic                               out_valid,
  output logic                               out_fired,
  output logic [pts_pkg::ID_W-1:0]           out_task_id,
  output logic [pts_pkg::NOW_W-1:0]          out_next_due_ms,
  output logic                               out_last
);
  import pts_pkg::*;

  localparam int SUM_W = TIME_BITS + 1;
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_TASKS);
  localparam logic [8:0] MAX_EXT = 9'(MAX_TASKS);

  // task table
  logic [ID_W-1:0]      id_mem_r     [MAX_TASKS];
  logic [PERIOD_W-1:0]  period_mem_r [MAX_TASKS];
  logic [TIME_BITS-1:0] due_mem_r    [MAX_TASKS];
  logic [ID_W-1:0]      id_rd_r;
  logic [PERIOD_W-1:0]  period_rd_r;
  logic [TIME_BITS-1:0] due_rd_r;

  logic [MAX_TASKS-1:0] en_r;
  logic [MAX_TASKS-1:0] fired_r;
  logic [CNT_W-1:0]     rows_r;
  logic                 changed_r;
  logic [TIME_BITS-1:0] earliest_r;
  logic [TIME_BITS-1:0] now_r;

  logic                 out_valid_r, out_fired_r, out_last_r;
  logic [ID_W-1:0]      out_task_id_r;
  logic [NOW_W-1:0]     out_next_due_r;

  logic [8:0]           slot_ext, count_ext;
  logic                 slot_ok;
  logic [IDX_W-1:0]     slot;
  logic [CNT_W-1:0]     rows_nxt;
  logic [63:0]          now_ext, earliest_ext;
  logic [TIME_BITS-1:0] now_in;
  logic [SUM_W-1:0]     due_sum;
  logic [TIME_BITS-1:0] sat_due;
  logic                 due_hit;
  logic [TIME_BITS-1:0] fold_val;
  logic                 fold_take;

  // load slot and commit count decode
  assign slot_ext  = 9'(in_row_index);
  assign slot_ok   = (slot_ext < MAX_EXT);
  assign slot      = slot_ext[IDX_W-1:0];
  assign count_ext = 9'(in_row_count);
  assign rows_nxt  = (count_ext > MAX_EXT) ? MAX_CNT : count_ext[CNT_W-1:0];

  // time width adaption
  assign now_ext      = 64'(in_now_ms);
  assign now_in       = now_ext[TIME_BITS-1:0];
  assign earliest_ext = 64'(earliest_r);

  // saturating re-arm time and due check
  assign due_sum = {1'b0, now_r} + SUM_W'(period_rd_r);
  assign sat_due = due_sum[TIME_BITS] ? '1 : due_sum[TIME_BITS-1:0];
  assign due_hit = (now_r >= due_rd_r);

  // running minimum, zero means none
  assign fold_val  = (ctl.arm_wr || due_hit) ? sat_due : due_rd_r;
  assign fold_take = (earliest_r == '0) || (fold_val < earliest_r);

  // status to controller
  assign sts.changed   = changed_r;
  assign sts.en_cur    = en_r[idx];
  assign sts.fired_cur = fired_r[idx];
  assign sts.reached   = (now_r >= earliest_r);
  assign rows          = rows_r;

  // id and period tables, written by load only
  always_ff @(posedge clk) begin
    if (ctl.load_wr && slot_ok) begin
      id_mem_r[slot]     <= in_row_id;
      period_mem_r[slot] <= in_row_interval;
    end
  end

  // due table, cleared by load, re-armed by the walks
  always_ff @(posedge clk) begin
    if (ctl.load_wr && slot_ok) begin
      due_mem_r[slot] <= '0;
    end else if (ctl.arm_wr || (ctl.fire_wr && due_hit)) begin
      due_mem_r[idx] <= sat_due;
    end
  end

  // registered table read
  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      id_rd_r     <= id_mem_r[idx];
      period_rd_r <= period_mem_r[idx];
      due_rd_r    <= due_mem_r[idx];
    end
  end

  // tick time
  always_ff @(posedge clk) begin
    if (ctl.tick_start) begin
      now_r <= now_in;
    end
  end

  // active flags, fired marks, row count, change flag, earliest due
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      en_r       <= '0;
      fired_r    <= '0;
      rows_r     <= '0;
      changed_r  <= 1'b0;
      earliest_r <= '0;
    end else begin
      if (ctl.load_wr && slot_ok) begin
        en_r[slot] <= in_row_active;
      end
      if (ctl.commit) begin
        rows_r    <= rows_nxt;
        changed_r <= 1'b1;
      end
      if (ctl.tick_start) begin
        fired_r <= '0;
      end else if (ctl.fire_wr && due_hit) begin
        fired_r[idx] <= 1'b1;
      end
      priority if (ctl.tick_start && changed_r) begin
        changed_r  <= 1'b0;
        earliest_r <= '0;
      end else if (ctl.fire_start) begin
        earliest_r <= '0;
      end else if ((ctl.arm_wr || ctl.fire_wr) && fold_take) begin
        earliest_r <= fold_val;
      end else begin
        earliest_r <= earliest_r;
      end
    end
  end

  // result strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= ctl.emit_fire || ctl.emit_sum;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (ctl.emit_fire || ctl.emit_sum) begin
      out_fired_r    <= ctl.emit_fire;
      out_task_id_r  <= ctl.emit_fire ? id_rd_r : '0;
      out_last_r     <= ctl.emit_sum;
      out_next_due_r <= earliest_ext[NOW_W-1:0];
    end
  end

  assign out_valid       = out_valid_r;
  assign out_fired       = out_fired_r;
  assign out_task_id     = out_task_id_r;
  assign out_next_due_ms = out_next_due_r;
  assign out_last        = out_last_r;

`ifndef SYNTH
  // a commit always leaves a pending change
  a_commit_marks: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.commit |=> changed_r)
    else $error("commit did not mark table changed");

  // row count saturates at table depth
  a_rows_bound: assert property (@(posedge clk) disable iff (!rst_n)
    rows_r <= MAX_CNT)
    else $error("row count beyond table depth");

  // summary transaction is flagged last
  a_sum_last: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.emit_sum |=> (out_valid && out_last && !out_fired))
    else $error("summary transaction malformed");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/periodic_task_scheduler.sv =====
// periodic task scheduler top level: controller and datapath
// depends on pts_pkg, pts_ctrl, pts_dp
`timescale 1ns / 1ps
`default_nettype none

// Usage: a command transaction is taken when start is high and busy is low.
// in_command selects load (write one row: index, id, active flag, interval),
// commit (set row count, mark the table changed) or tick (current time in
// in_now_ms). Load and commit give no results; busy stays low. A tick
// raises busy and walks the task table held in block memory, one row read
// per step through the single read port of the table:
//   re-arm walk after a commit: reads and re-arms each active row
//   fire walk when now has reached the earliest due time: fires and
//   re-arms each due active row
//   report walk, only after a fire walk: one result per fired row
//   plus tick accept, due check and summary
// Firing results come during the report walk, each for exactly one cycle
// with out_valid high; the last (out_last high) is the summary, shown in
// the same cycle that busy falls, with the earliest due time, 0 for none.
// The receiver cannot stall; every result must be taken when shown.
// Reset clears the active flags, row count, change flag and earliest due
// time; ids, intervals and due times hold no value until loaded.
module periodic_task_scheduler #(
  parameter int MAX_TASKS = pts_pkg::MAX_TASKS_DEF,
  parameter int TIME_BITS = pts_pkg::TIME_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [pts_pkg::CMD_W-1:0]     in_command,
  input  wire logic [pts_pkg::INDEX_W-1:0]   in_row_index,
  input  wire logic [pts_pkg::ID_W-1:0]      in_row_id,
  input  wire logic                          in_row_active,
  input  wire logic [pts_pkg::PERIOD_W-1:0]  in_row_interval,
  input  wire logic [pts_pkg::COUNT_W-1:0]   in_row_count,
  input  wire logic [pts_pkg::NOW_W-1:0]     in_now_ms,
  output logic                               out_valid,
  output logic                               out_fired,
  output logic [pts_pkg::ID_W-1:0]           out_task_id,
  output logic [pts_pkg::NOW_W-1:0]          out_next_due_ms,
  output logic                               out_last
);
  import pts_pkg::*;

  localparam int CNT_W = $clog2(MAX_TASKS + 1);
  localparam int IDX_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;

  pts_ctl_t          ctl;
  pts_sts_t          sts;
  logic [IDX_W-1:0]  idx;
  logic [CNT_W-1:0]  rows;

  // sequencing
  pts_ctrl #(
    .MAX_TASKS (MAX_TASKS)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .in_command (in_command),
    .rows       (rows),
    .sts        (sts),
    .ctl        (ctl),
    .idx        (idx),
    .busy       (busy)
  );

  // table and arithmetic
  pts_dp #(
    .MAX_TASKS (MAX_TASKS),
    .TIME_BITS (TIME_BITS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .ctl             (ctl),
    .idx             (idx),
    .in_row_index    (in_row_index),
    .in_row_id       (in_row_id),
    .in_row_active   (in_row_active),
    .in_row_interval (in_row_interval),
    .in_row_count    (in_row_count),
    .in_now_ms       (in_now_ms),
    .sts             (sts),
    .rows            (rows),
    .out_valid       (out_valid),
    .out_fired       (out_fired),
    .out_task_id     (out_task_id),
    .out_next_due_ms (out_next_due_ms),
    .out_last        (out_last)
  );

endmodule

`default_nettype wire

// ===== tb/sv/tb_top.sv =====
// testbench for the periodic task scheduler: random and directed commands
// against a self-contained prediction of the task table, results checked in order
// depends on pts_pkg and periodic_task_scheduler
`timescale 1ns / 1ps

module tb_top;
  import pts_pkg::*;

  localparam int TASKS = MAX_TASKS_DEF;
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam int ITEM_TARGET = 170;
  localparam int TAIL_CYCLES = 100;
  localparam int QUIET_LIMIT = 2000;
  localparam int PRINT_LIMIT = 50;

  // one command transaction as driven on the in_ ports
  typedef struct {
    logic [CMD_W-1:0]    command;
    logic [INDEX_W-1:0]  row_index;
    logic [ID_W-1:0]     row_id;
    logic                row_active;
    logic [PERIOD_W-1:0] row_interval;
    logic [COUNT_W-1:0]  row_count;
    logic [NOW_W-1:0]    now_ms;
    bit                  drain_first;
  } sched_cmd_t;

  // one result transaction
  typedef struct {
    logic             fired;
    logic [ID_W-1:0]  task_id;
    logic [NOW_W-1:0] next_due;
    logic             last;
  } sched_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [CMD_W-1:0] in_command = '0;
  logic [INDEX_W-1:0] in_row_index = '0;
  logic [ID_W-1:0] in_row_id = '0;
  logic in_row_active = 1'b0;
  logic [PERIOD_W-1:0] in_row_interval = '0;
  logic [COUNT_W-1:0] in_row_count = '0;
  logic [NOW_W-1:0] in_now_ms = '0;
  logic out_valid;
  logic out_fired;
  logic [ID_W-1:0] out_task_id;
  logic [NOW_W-1:0] out_next_due_ms;
  logic out_last;

  periodic_task_scheduler i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_command      (in_command),
    .in_row_index    (in_row_index),
    .in_row_id       (in_row_id),
    .in_row_active   (in_row_active),
    .in_row_interval (in_row_interval),
    .in_row_count    (in_row_count),
    .in_now_ms       (in_now_ms),
    .out_valid       (out_valid),
    .out_fired       (out_fired),
    .out_task_id     (out_task_id),
    .out_next_due_ms (out_next_due_ms),
    .out_last        (out_last)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  sched_cmd_t    cmd_backlog[$];
  sched_result_t expected_results[$];
  sched_cmd_t    cmd_on_bus;
  int unsigned   mismatch_count = 0;
  int unsigned   real_cmds = 0;
  int unsigned   burst_left = 1;
  int unsigned   gap_left = 0;
  int unsigned   quiet_cycles = 0;

  // predicted task table
  logic [ID_W-1:0]     tbl_id[TASKS];
  bit                  tbl_active[TASKS];
  logic [PERIOD_W-1:0] tbl_period[TASKS];
  logic [NOW_W-1:0]    tbl_due[TASKS];
  int unsigned         tbl_rows = 0;
  bit                  tbl_changed = 1'b0;
  logic [NOW_W-1:0]    soonest_due = '0;

  // due time = now + interval, pinned at all ones on overflow
  function automatic logic [NOW_W-1:0] rearm_time(logic [NOW_W-1:0] t,
                                                  logic [PERIOD_W-1:0] p);
    logic [NOW_W:0] s;
    s = {1'b0, t} + {{(NOW_W + 1 - PERIOD_W){1'b0}}, p};
    return s[NOW_W] ? '1 : s[NOW_W-1:0];
  endfunction

  // zero stands for none, which any due time replaces
  function automatic void fold_soonest(logic [NOW_W-1:0] d);
    if (soonest_due == '0 || d < soonest_due) soonest_due = d;
  endfunction

  // update the table for one accepted command and queue its results
  task automatic predict_command(sched_cmd_t c);
    logic [ID_W-1:0] fired_ids[$];
    sched_result_t r;
    logic [NOW_W-1:0] t;
    case (c.command)
      CMD_LOAD: begin
        tbl_id[c.row_index]     = c.row_id;
        tbl_active[c.row_index] = c.row_active;
        tbl_period[c.row_index] = c.row_interval;
        tbl_due[c.row_index]    = '0;
      end
      CMD_COMMIT: begin
        tbl_rows    = (c.row_count > TASKS) ? TASKS : c.row_count;
        tbl_changed = 1'b1;
      end
      CMD_TICK: begin
        t = c.now_ms;
        // pending change: re-arm every active row in use from now
        if (tbl_changed) begin
          tbl_changed = 1'b0;
          soonest_due = '0;
          for (int i = 0; i < tbl_rows; i++) begin
            if (tbl_active[i]) begin
              tbl_due[i] = rearm_time(t, tbl_period[i]);
              fold_soonest(tbl_due[i]);
            end
          end
        end
        // fire walk in row order
        if (t >= soonest_due) begin
          soonest_due = '0;
          for (int i = 0; i < tbl_rows; i++) begin
            if (tbl_active[i]) begin
              if (t >= tbl_due[i]) begin
                tbl_due[i] = rearm_time(t, tbl_period[i]);
                fired_ids.insert(fired_ids.size(), tbl_id[i]);
              end
              fold_soonest(tbl_due[i]);
            end
          end
        end
        foreach (fired_ids[k]) begin
          r = '{fired: 1'b1, task_id: fired_ids[k], next_due: soonest_due, last: 1'b0};
          expected_results.insert(expected_results.size(), r);
        end
        r = '{fired: 1'b0, task_id: '0, next_due: soonest_due, last: 1'b1};
        expected_results.insert(expected_results.size(), r);
      end
      default: ;
    endcase
  endtask

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    if (mismatch_count < PRINT_LIMIT)
      $display("%0t mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
    mismatch_count++;
  endtask

  // driver: present backlog items in bursts, predict on each accepted transaction
  always @(posedge clk) begin : cmd_driver
    bit present;
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      present = start;
      if (start && !busy) begin
        predict_command(cmd_on_bus);
        present = 1'b0;
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 24);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        end
      end
      if (!present) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (cmd_backlog.size() > 0 &&
                     !(cmd_backlog[0].drain_first && (expected_results.size() > 0 || busy))) begin
          cmd_on_bus = cmd_backlog.pop_front();
          in_command      <= cmd_on_bus.command;
          in_row_index    <= cmd_on_bus.row_index;
          in_row_id       <= cmd_on_bus.row_id;
          in_row_active   <= cmd_on_bus.row_active;
          in_row_interval <= cmd_on_bus.row_interval;
          in_row_count    <= cmd_on_bus.row_count;
          in_now_ms       <= cmd_on_bus.now_ms;
          present = 1'b1;
        end
      end
      start <= present;
    end
  end

  // monitor: every shown result is taken and checked against the oldest expectation
  always @(posedge clk) begin : result_monitor
    sched_result_t want;
    if (rst_n && out_valid) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result, task_id", 64'(out_task_id), '0);
      end else begin
        want = expected_results.pop_front();
        if (out_fired !== want.fired)
          report_mismatch("fired", 64'(out_fired), 64'(want.fired));
        if (out_task_id !== want.task_id)
          report_mismatch("task_id", 64'(out_task_id), 64'(want.task_id));
        if (out_next_due_ms !== want.next_due)
          report_mismatch("next_due_ms", 64'(out_next_due_ms), 64'(want.next_due));
        if (out_last !== want.last)
          report_mismatch("last", 64'(out_last), 64'(want.last));
      end
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk) begin
    if (rst_n) begin
      if ((start && !busy) || out_valid) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  function automatic logic [NOW_W-1:0] rand_time();
    logic [63:0] w;
    w = {$urandom(), $urandom()};
    return w[NOW_W-1:0];
  endfunction

  // mostly short periods, with zero and very long ones mixed in
  function automatic logic [PERIOD_W-1:0] rand_interval();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return $urandom();
      2: return '1;
      default: return $urandom_range(1, 40);
    endcase
  endfunction

  // every field random so unused ones toggle too
  function automatic sched_cmd_t rand_cmd(logic [CMD_W-1:0] code);
    sched_cmd_t c;
    c.command      = code;
    c.row_index    = INDEX_W'($urandom());
    c.row_id       = $urandom();
    c.row_active   = 1'($urandom_range(0, 1));
    c.row_interval = $urandom();
    c.row_count    = COUNT_W'($urandom());
    c.now_ms       = rand_time();
    c.drain_first  = ($urandom_range(0, 19) == 0);
    return c;
  endfunction

  task automatic push_cmd(sched_cmd_t c);
    cmd_backlog.insert(cmd_backlog.size(), c);
    if (c.command != CMD_UNUSED) real_cmds++;
  endtask

  task automatic push_load(int idx, logic [ID_W-1:0] id, logic act,
                           logic [PERIOD_W-1:0] ival);
    sched_cmd_t c;
    c = rand_cmd(CMD_LOAD);
    c.row_index = INDEX_W'(idx);
    c.row_id = id;
    c.row_active = act;
    c.row_interval = ival;
    push_cmd(c);
  endtask

  task automatic push_commit(int cnt);
    sched_cmd_t c;
    c = rand_cmd(CMD_COMMIT);
    c.row_count = COUNT_W'(cnt);
    push_cmd(c);
  endtask

  task automatic push_tick(logic [NOW_W-1:0] t);
    sched_cmd_t c;
    c = rand_cmd(CMD_TICK);
    c.now_ms = t;
    push_cmd(c);
  endtask

  initial begin
    sched_cmd_t c;
    logic [NOW_W-1:0] t_base;
    int unsigned pick;

    foreach (tbl_active[i]) begin
      tbl_id[i] = '0;
      tbl_active[i] = 1'b0;
      tbl_period[i] = '0;
      tbl_due[i] = '0;
    end

    // directed: empty table, unused command, full load, zero and max times
    push_tick('0);
    push_cmd(rand_cmd(CMD_UNUSED));
    push_commit(0);
    push_tick(rand_time());
    push_load(0, '0, 1'b1, '0);
    push_load(1, '1, 1'b1, '1);
    push_load(2, $urandom(), 1'b0, $urandom_range(1, 20));
    for (int i = 3; i < TASKS; i++)
      push_load(i, $urandom(), $urandom_range(0, 3) != 0, $urandom_range(1, 20));
    push_commit(31);
    push_tick('0);
    push_tick('1);
    push_commit(17);
    push_tick('1 - 3);

    // random: reload and commit, then ticks on a mostly advancing clock
    t_base = NOW_W'($urandom_range(0, 1000));
    c = rand_cmd(CMD_TICK);
    c.now_ms = t_base;
    c.drain_first = 1'b1;
    push_cmd(c);
    while (real_cmds < ITEM_TARGET) begin
      pick = $urandom_range(0, 19);
      if (pick < 4) begin
        repeat ($urandom_range(1, 4))
          push_load($urandom_range(0, TASKS - 1), $urandom(), $urandom_range(0, 3) != 0,
                    rand_interval());
        push_commit(($urandom_range(0, 4) == 0) ? $urandom_range(0, 31)
                                                : $urandom_range(1, TASKS));
      end else if (pick < 16) begin
        t_base = t_base + NOW_W'($urandom_range(0, 25));
        push_tick(t_base);
      end else if (pick == 16) begin
        push_cmd(rand_cmd(CMD_UNUSED));
      end else if (pick == 17) begin
        push_tick(rand_time());
      end else if (pick == 18) begin
        push_load($urandom_range(0, TASKS - 1), $urandom(), 1'b1, rand_interval());
      end else begin
        t_base = ($urandom_range(0, 1) == 0) ? rand_time()
                                             : '1 - NOW_W'($urandom_range(0, 100));
      end
    end

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    while (cmd_backlog.size() > 0 || start || expected_results.size() > 0)
      @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/pts_pkg.sv
hw/rtl/pts_ctrl.sv
hw/rtl/pts_dp.sv
hw/rtl/periodic_task_scheduler.sv
tb/sv/tb_top.sv
